### rtl/dss_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Dual stack package
// Shared types for the two-stacks-in-one-memory core.
// ---------------------------------------------------------------------------
package dss_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_LO = 2'd0,
		OP_PUSH_HI = 2'd1,
		OP_POP_LO  = 2'd2,
		OP_POP_HI  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		status_t            status;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic load;
		logic cfg_take;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
	} dp_stat_t;

endpackage
`default_nettype wire

### rtl/dss_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/dss_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Dual stack controller
// Sequences one beat at a time through memory access and result load.
// ---------------------------------------------------------------------------
module dss_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic              cfg_wr_en,
	input  wire dss_pkg::dp_stat_t stat,
	output dss_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic {
		S_IDLE,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.take     = in_valid && (state_q == S_IDLE);
		cmd.load     = (state_q == S_LOAD) && (!out_valid_q || !out_stall);
		cmd.cfg_take = cfg_wr_en && stat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.take) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// A result that waits for its load must not be overwritten by a new take.
	a_no_take_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !cmd.take)
		else $error("take issued while a result is pending");

	// Every accepted beat is followed by the load phase.
	a_take_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == S_LOAD))
		else $error("accepted beat did not reach the load phase");

endmodule
`default_nettype wire

### rtl/dss_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Dual stack datapath
// Stack counters, capacity register, shared memory and result register.
// ---------------------------------------------------------------------------
module dss_datapath #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dss_pkg::in_item_t  in_data,
	output dss_pkg::out_item_t      out_data,
	input  wire logic [8:0]         cfg_wr_data,
	input  wire dss_pkg::ctrl_cmd_t cmd,
	output dss_pkg::dp_stat_t       stat
);

	localparam int CW      = $clog2(DEPTH + 1);
	localparam int AW      = $clog2(DEPTH);
	localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

	logic [CW-1:0]         low_q;
	logic [CW-1:0]         high_q;
	logic [CW-1:0]         cap_q;
	logic [CW-1:0]         cap_new;
	logic [CW:0]           cnt_sum;
	logic                  full;
	logic [CW-1:0]         addr_full;
	logic                  mem_wr;
	logic                  mem_rd;
	logic                  low_inc;
	logic                  low_dec;
	logic                  high_inc;
	logic                  high_dec;
	dss_pkg::status_t      item_status;
	dss_pkg::status_t      pend_status_q;
	logic                  pend_read_q;
	logic [DATA_WIDTH+31:0] push_ext;
	logic [DATA_WIDTH+31:0] rd_ext;
	logic [DATA_WIDTH+31:0] mask_ext;
	logic [DATA_WIDTH-1:0] rd_data;
	dss_pkg::out_item_t    out_q;

	always_comb begin
		if (cfg_wr_data < 9'd2) begin
			cap_new = CW'(2);
		end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cfg_wr_data);
		end
	end

	assign cnt_sum    = {1'b0, low_q} + {1'b0, high_q};
	assign full       = (cnt_sum >= {1'b0, cap_q});
	assign stat.empty = (low_q == '0) && (high_q == '0);

	always_comb begin
		mem_wr      = 1'b0;
		mem_rd      = 1'b0;
		low_inc     = 1'b0;
		low_dec     = 1'b0;
		high_inc    = 1'b0;
		high_dec    = 1'b0;
		item_status = dss_pkg::STAT_OK;
		addr_full   = low_q;
		unique case (in_data.opcode)
			dss_pkg::OP_PUSH_LO: begin
				addr_full = low_q;
				if (full) begin
					item_status = dss_pkg::STAT_OVERFLOW;
				end else begin
					mem_wr  = 1'b1;
					low_inc = 1'b1;
				end
			end
			dss_pkg::OP_PUSH_HI: begin
				addr_full = cap_q - high_q - CW'(1);
				if (full) begin
					item_status = dss_pkg::STAT_OVERFLOW;
				end else begin
					mem_wr   = 1'b1;
					high_inc = 1'b1;
				end
			end
			dss_pkg::OP_POP_LO: begin
				addr_full = low_q - CW'(1);
				if (low_q == '0) begin
					item_status = dss_pkg::STAT_UNDERFLOW;
				end else begin
					mem_rd  = 1'b1;
					low_dec = 1'b1;
				end
			end
			dss_pkg::OP_POP_HI: begin
				addr_full = cap_q - high_q;
				if (high_q == '0) begin
					item_status = dss_pkg::STAT_UNDERFLOW;
				end else begin
					mem_rd   = 1'b1;
					high_dec = 1'b1;
				end
			end
			default: begin
				item_status = dss_pkg::STAT_OK;
			end
		endcase
	end

	assign push_ext = {{DATA_WIDTH{1'b0}}, in_data.push_value};

	dss_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.take && mem_wr),
		.wr_addr(addr_full[AW-1:0]),
		.wr_data(push_ext[DATA_WIDTH-1:0]),
		.rd_en  (cmd.take && mem_rd),
		.rd_addr(addr_full[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			cap_q  <= CW'(CAP_RST);
		end else begin
			if (cmd.take) begin
				if (low_inc) begin
					low_q <= low_q + CW'(1);
				end else if (low_dec) begin
					low_q <= low_q - CW'(1);
				end
				if (high_inc) begin
					high_q <= high_q + CW'(1);
				end else if (high_dec) begin
					high_q <= high_q - CW'(1);
				end
			end
			if (cmd.cfg_take) begin
				cap_q <= cap_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_status_q <= item_status;
			pend_read_q   <= mem_rd;
		end
	end

	assign rd_ext   = {32'd0, rd_data};
	assign mask_ext = {32'd0, {DATA_WIDTH{1'b1}}};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.status <= pend_status_q;
			if (pend_read_q) begin
				out_q.pop_value <= rd_ext[31:0];
			end else if (pend_status_q == dss_pkg::STAT_UNDERFLOW) begin
				out_q.pop_value <= mask_ext[31:0];
			end else begin
				out_q.pop_value <= '0;
			end
		end
	end

	assign out_data = out_q;

	// The two stacks together never hold more words than the capacity.
	a_sum_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_sum <= {1'b0, cap_q})
		else $error("stack counts exceed capacity");

	// Capacity always stays inside its clamped range.
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cap_q) >= 32'd2) && (32'(cap_q) <= 32'(DEPTH)))
		else $error("capacity out of range");

	// A push that finds room grows the total by exactly one word.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && mem_wr) |=> (cnt_sum == $past(cnt_sum) + (CW + 1)'(1)))
		else $error("accepted push did not add one word");

endmodule
`default_nettype wire

### rtl/dual_stack_shared_memory_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Dual stack shared memory core
// Two LIFO stacks in one memory: stack one grows up from entry 0, stack two
// grows down from entry capacity-1.
//
//   Channel | Direction | Handshake            | Beat
//   in      | input     | in_valid / in_stall   | in_item_t (opcode, push_value)
//   out     | output    | out_valid / out_stall | out_item_t (pop_value, status)
//   cfg     | input     | cfg_wr_en             | 9-bit capacity
//
// An item passes through the memory access and then a load of the
// result from the registered read port of the shared RAM.
// A finished result may wait in the output register while the next beat is
// accepted; a further result waits until that register is taken.
// Reset clears both stack counts and sets capacity; the memory needs no
// clearing pass since no entry is read before it is written.
// ---------------------------------------------------------------------------
module dual_stack_shared_memory_core #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire dss_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dss_pkg::out_item_t      out_data,
	input  wire logic               cfg_wr_en,
	input  wire logic [8:0]         cfg_wr_data
);

	dss_pkg::ctrl_cmd_t cmd;
	dss_pkg::dp_stat_t  stat;

	dss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_wr_en(cfg_wr_en),
		.stat     (stat),
		.cmd      (cmd)
	);

	dss_datapath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.out_data   (out_data),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule
`default_nettype wire

### sim/tb_dual_stack_shared_memory_core.sv
// ---------------------------------------------------------------------------
// Dual stack shared memory core testbench
// Drives push and pop beats into both stacks and checks every result beat
// against a cycle-free predictor of the two stacks and their shared memory.
// Covers empty pops, overflow at the meeting point, word extremes, capacity
// clamping, capacity writes that must be ignored, and long random traffic
// that fills and drains the stacks, with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb_dual_stack_shared_memory_core;

	localparam int DEPTH       = 256;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_BEATS = 1000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	dss_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	dss_pkg::out_item_t out_data;
	logic      cfg_wr_en;
	logic [8:0] cfg_wr_data;

	logic [31:0] stack_words [DEPTH];
	int lo_depth;
	int hi_depth;
	int cur_capacity;
	dss_pkg::out_item_t pending_results [$];

	int  error_count;
	int  beats_sent;
	int  beats_checked;
	int  overflow_seen;
	int  underflow_seen;
	int  capacity_writes;
	int  cycle_count;
	int  stall_left;
	int  stall_len;
	bit  steady;

	dual_stack_shared_memory_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void apply_capacity(input logic [8:0] value);
		if (lo_depth != 0 || hi_depth != 0)
			return;
		if (value < 2)
			cur_capacity = 2;
		else if (value > DEPTH)
			cur_capacity = DEPTH;
		else
			cur_capacity = int'(value);
	endfunction

	function automatic dss_pkg::out_item_t predict_stacks(input dss_pkg::in_item_t item);
		dss_pkg::out_item_t r;
		logic full;
		int addr;
		r.pop_value = '0;
		r.status = dss_pkg::STAT_OK;
		full = (lo_depth + hi_depth) >= cur_capacity;
		case (item.opcode)
			dss_pkg::OP_PUSH_LO: begin
				if (full) begin
					r.status = dss_pkg::STAT_OVERFLOW;
				end else begin
					stack_words[lo_depth] = item.push_value;
					lo_depth++;
				end
			end
			dss_pkg::OP_PUSH_HI: begin
				if (full) begin
					r.status = dss_pkg::STAT_OVERFLOW;
				end else begin
					hi_depth++;
					addr = cur_capacity - hi_depth;
					stack_words[addr] = item.push_value;
				end
			end
			dss_pkg::OP_POP_LO: begin
				if (lo_depth == 0) begin
					r.pop_value = -32'sd1;
					r.status = dss_pkg::STAT_UNDERFLOW;
				end else begin
					lo_depth--;
					r.pop_value = stack_words[lo_depth];
				end
			end
			default: begin
				if (hi_depth == 0) begin
					r.pop_value = -32'sd1;
					r.status = dss_pkg::STAT_UNDERFLOW;
				end else begin
					addr = cur_capacity - hi_depth;
					r.pop_value = stack_words[addr];
					hi_depth--;
				end
			end
		endcase
		if (r.status == dss_pkg::STAT_OVERFLOW)
			overflow_seen++;
		if (r.status == dss_pkg::STAT_UNDERFLOW)
			underflow_seen++;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_beat(input dss_pkg::out_item_t got);
		dss_pkg::out_item_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected beat pop_value %0d status %0d",
				got.pop_value, got.status));
			return;
		end
		want = pending_results.pop_front();
		beats_checked++;
		if (got.pop_value !== want.pop_value)
			report_mismatch($sformatf("pop_value %0d, wanted %0d",
				got.pop_value, want.pop_value));
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[dual_stack_shared_memory_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_beat(out_data);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_len = pick_gap();
			stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
			out_stall <= (stall_len > 0);
		end
	end

	task automatic send_beat(input dss_pkg::opcode_t op, input logic [31:0] value);
		dss_pkg::in_item_t item;
		int gap;
		item.opcode = op;
		item.push_value = value;
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_stacks(item));
		beats_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic cfg_write(input logic [8:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		apply_capacity(value);
		capacity_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_reset_and_extremes();
		send_beat(dss_pkg::OP_POP_LO, $urandom);
		send_beat(dss_pkg::OP_POP_HI, $urandom);
		send_beat(dss_pkg::OP_PUSH_LO, 32'h8000_0000);
		send_beat(dss_pkg::OP_PUSH_LO, 32'h7FFF_FFFF);
		send_beat(dss_pkg::OP_PUSH_HI, 32'hFFFF_FFFF);
		send_beat(dss_pkg::OP_PUSH_HI, 32'h0000_0000);
		send_beat(dss_pkg::OP_POP_HI, $urandom);
		send_beat(dss_pkg::OP_POP_LO, $urandom);
		send_beat(dss_pkg::OP_POP_HI, $urandom);
		send_beat(dss_pkg::OP_POP_LO, $urandom);
	endtask

	task automatic test_smallest_capacity();
		cfg_write(9'd0);
		send_beat(dss_pkg::OP_PUSH_LO, 32'h1234_5678);
		send_beat(dss_pkg::OP_PUSH_HI, 32'hDEAD_BEEF);
		send_beat(dss_pkg::OP_PUSH_LO, 32'h5555_5555);
		send_beat(dss_pkg::OP_PUSH_HI, 32'hAAAA_AAAA);
		cfg_write(9'h1FF);
		send_beat(dss_pkg::OP_PUSH_LO, 32'h0F0F_0F0F);
		send_beat(dss_pkg::OP_POP_LO, $urandom);
		send_beat(dss_pkg::OP_POP_LO, $urandom);
		send_beat(dss_pkg::OP_PUSH_LO, 32'hC001_D00D);
		send_beat(dss_pkg::OP_PUSH_HI, 32'h0000_0001);
		send_beat(dss_pkg::OP_POP_HI, $urandom);
		send_beat(dss_pkg::OP_POP_LO, $urandom);
		cfg_write(9'd1);
		send_beat(dss_pkg::OP_PUSH_HI, 32'h8000_0001);
		send_beat(dss_pkg::OP_POP_HI, $urandom);
	endtask

	task automatic test_random_traffic();
		int phase;
		int sent;
		int extra;
		logic [8:0] value;
		dss_pkg::opcode_t op;
		phase = 0;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case (phase % 4)
				0: value = 9'($urandom_range(3, 8));
				1: value = 9'($urandom_range(9, 48));
				2: value = 9'($urandom_range(0, 2));
				default: value = 9'($urandom_range(2, 20));
			endcase
			if (phase == 3)
				value = $urandom_range(0, 1) ? 9'h1FF : 9'd256;
			cfg_write(value);
			steady = ($urandom_range(0, 3) == 0);
			extra = $urandom_range(1, 4);
			while (extra > 0) begin
				if (lo_depth + hi_depth >= cur_capacity)
					extra--;
				if ($urandom_range(0, 9) < 8)
					op = $urandom_range(0, 1) ? dss_pkg::OP_PUSH_HI : dss_pkg::OP_PUSH_LO;
				else
					op = $urandom_range(0, 1) ? dss_pkg::OP_POP_HI : dss_pkg::OP_POP_LO;
				send_beat(op, $urandom);
				sent++;
			end
			extra = $urandom_range(1, 4);
			while (extra > 0) begin
				if (lo_depth == 0 && hi_depth == 0)
					extra--;
				if ($urandom_range(0, 9) < 8)
					op = $urandom_range(0, 1) ? dss_pkg::OP_POP_HI : dss_pkg::OP_POP_LO;
				else
					op = dss_pkg::opcode_t'($urandom_range(0, 3));
				send_beat(op, $urandom);
				sent++;
			end
			steady = 1'b0;
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		error_count = 0;
		beats_sent = 0;
		beats_checked = 0;
		overflow_seen = 0;
		underflow_seen = 0;
		capacity_writes = 0;
		steady = 1'b0;
		lo_depth = 0;
		hi_depth = 0;
		cur_capacity = DEPTH;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_extremes();
		test_smallest_capacity();
		test_random_traffic();
		cfg_write(9'd256);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d beats, checked %0d results, %0d overflows, %0d underflows,",
			beats_sent, beats_checked, overflow_seen, underflow_seen);
		$display("%0d capacity writes, %0d mismatches", capacity_writes, error_count);
		if (error_count == 0)
			$display("[dual_stack_shared_memory_core] OK");
		else
			$display("[dual_stack_shared_memory_core] ERROR");
		$finish;
	end

endmodule
